// ----- rtl/carm_pkg.sv -----
`timescale 1ns / 1ps

package carm_pkg;

    // default sizes
    localparam int CARM_COMB_COUNT     = 8;
    localparam int CARM_ALLPASS_COUNT  = 4;
    localparam int CARM_LONGEST_COMB   = 2048;
    localparam int CARM_INTERNAL_WIDTH = 24;

    // allpass lines are laid out at a fixed pitch
    localparam int LONGEST_AP = 1024;
    localparam int AP_POS_W   = 10;

    // line lengths, wide enough for the largest comb pitch
    localparam int LEN_W      = 14;
    localparam int COMB_SLOTS = 16;
    localparam int AP_SLOTS   = 8;

    localparam logic [LEN_W-1:0] COMB_LEN_TAB [COMB_SLOTS] = '{
        14'd1116, 14'd1188, 14'd1277, 14'd1356, 14'd1422, 14'd1491, 14'd1557, 14'd1617,
        14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0
    };

    localparam logic [LEN_W-1:0] AP_LEN_TAB [AP_SLOTS] = '{
        14'd556, 14'd441, 14'd341, 14'd225, 14'd0, 14'd0, 14'd0, 14'd0
    };

    // configuration register map
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_GAIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DAMP_COEFF    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROOM_FEEDBACK = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WET_GAIN      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRY_GAIN      = 3'd4;

    localparam logic [15:0] RST_INPUT_GAIN    = 16'd983;
    localparam logic [15:0] RST_DAMP_COEFF    = 16'd13107;
    localparam logic [15:0] RST_ROOM_FEEDBACK = 16'd55050;
    localparam logic [15:0] RST_WET_GAIN      = 16'd16220;
    localparam logic [15:0] RST_DRY_GAIN      = 16'd13107;

    typedef struct packed {
        logic [15:0] damp_coeff;
        logic [15:0] room_feedback;
    } t_comb_cfg;

    // round half up, then arithmetic shift right
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic signed [63:0] half;
        half = (64'sd1 <<< s) >>> 1;
        return (v + half) >>> s;
    endfunction

    // clamp to a signed range of w bits
    function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
                                                  input int unsigned w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

// ----- rtl/comb_allpass_reverb_mono.sv -----
`timescale 1ns / 1ps

// Mono reverberator: each input transaction carries one Q1.15 sample and yields one
// Q1.15 output transaction. The sample is scaled by input_gain, run through
// COMB_COUNT damped feedback combs (summed) and ALLPASS_COUNT series allpass stages,
// then mixed as wet plus dry and clipped to full scale. The comb lines share one
// delay memory and the allpass lines another, each with one write and one registered
// read port; the combs stream through that port one line per cycle in a four stage
// pipeline, the allpass stages follow one per cycle in series. The next sample is
// accepted only after the previous result is loaded into the output register. A
// finished result waits in the output register while the next sample is accepted and
// processed. Delay lines start silent after reset with no clearing pass: a line reads
// as zero until its first lap has been written. Configuration writes are expected only
// while no sample is in flight.

module comb_allpass_reverb_mono #(
    parameter int COMB_COUNT     = carm_pkg::CARM_COMB_COUNT,
    parameter int ALLPASS_COUNT  = carm_pkg::CARM_ALLPASS_COUNT,
    parameter int LONGEST_COMB   = carm_pkg::CARM_LONGEST_COMB,
    parameter int INTERNAL_WIDTH = carm_pkg::CARM_INTERNAL_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [carm_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [15:0]                     i_cfg_data,
    // input sample channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [15:0]              i_audio_in,
    // output sample channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [15:0]              o_audio_out
);
    import carm_pkg::*;

    localparam int W   = INTERNAL_WIDTH;
    localparam int SH  = W - 16;
    localparam int MXW = W + 5;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a sample
    localparam logic [2:0] S_GAIN = 3'd1;  // input and dry products
    localparam logic [2:0] S_XIN  = 3'd2;  // round scaled input, launch combs
    localparam logic [2:0] S_COMB = 3'd3;  // comb pipeline busy
    localparam logic [2:0] S_AP   = 3'd4;  // allpass chain busy
    localparam logic [2:0] S_WET  = 3'd5;  // wet product
    localparam logic [2:0] S_MIX  = 3'd6;  // wet plus dry
    localparam logic [2:0] S_OUT  = 3'd7;  // final round, clip, hand to output

    logic [2:0] r_state, n_state;

    // configuration registers
    logic [15:0] r_input_gain, r_damp_coeff, r_room_feedback, r_wet_gain, r_dry_gain;

    // datapath registers
    logic signed [15:0]    r_x16;
    logic signed [W+16:0]  r_gain_p;
    logic signed [W+16:0]  r_dry_p;
    logic signed [W+16:0]  r_wet_p;
    logic signed [MXW-1:0] r_mix;
    logic signed [15:0]    r_audio_out;
    logic                  r_out_valid;

    logic signed [W-1:0] xw;
    logic signed [W-1:0] xin;
    logic                out_free;
    logic                load_out;

    t_comb_cfg           comb_cfg;
    logic                comb_start, comb_done;
    logic signed [W-1:0] comb_sum;
    logic                ap_start, ap_done;
    logic signed [W-1:0] ap_x;

    // sample widened to the internal format
    assign xw  = W'(r_x16) <<< SH;
    assign xin = W'(sat_to(rnd_shift(64'(r_gain_p), 16), W));

    assign comb_cfg.damp_coeff    = r_damp_coeff;
    assign comb_cfg.room_feedback = r_room_feedback;

    assign comb_start = (r_state == S_XIN);
    assign ap_start   = (r_state == S_COMB) && comb_done;

    // the output register frees up in the same cycle it is taken
    assign out_free = !r_out_valid || i_ready;
    assign load_out = (r_state == S_OUT) && out_free;

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_audio_out = r_audio_out;

    carm_comb_bank #(
        .COMB_COUNT     (COMB_COUNT),
        .LONGEST_COMB   (LONGEST_COMB),
        .INTERNAL_WIDTH (INTERNAL_WIDTH)
    ) u_comb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (comb_cfg),
        .i_start (comb_start),
        .i_xin   (xin),
        .o_done  (comb_done),
        .o_sum   (comb_sum)
    );

    carm_allpass_chain #(
        .ALLPASS_COUNT  (ALLPASS_COUNT),
        .INTERNAL_WIDTH (INTERNAL_WIDTH)
    ) u_allpass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ap_start),
        .i_x     (comb_sum),
        .o_done  (ap_done),
        .o_x     (ap_x)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: n_state = S_XIN;
            S_XIN:  n_state = S_COMB;
            S_COMB: begin
                if (comb_done) begin
                    n_state = S_AP;
                end
            end
            S_AP: begin
                if (ap_done) begin
                    n_state = S_WET;
                end
            end
            S_WET: n_state = S_MIX;
            S_MIX: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_input_gain    <= RST_INPUT_GAIN;
            r_damp_coeff    <= RST_DAMP_COEFF;
            r_room_feedback <= RST_ROOM_FEEDBACK;
            r_wet_gain      <= RST_WET_GAIN;
            r_dry_gain      <= RST_DRY_GAIN;
        end else begin
            r_state <= n_state;

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            // unknown register indexes are ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INPUT_GAIN:    r_input_gain    <= i_cfg_data;
                    REG_DAMP_COEFF:    r_damp_coeff    <= i_cfg_data;
                    REG_ROOM_FEEDBACK: r_room_feedback <= i_cfg_data;
                    REG_WET_GAIN:      r_wet_gain      <= i_cfg_data;
                    REG_DRY_GAIN:      r_dry_gain      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x16 <= i_audio_in;
        end
        if (r_state == S_GAIN) begin
            r_gain_p <= xw * $signed({1'b0, r_input_gain});
            r_dry_p  <= xw * $signed({1'b0, r_dry_gain});
        end
        if (r_state == S_WET) begin
            r_wet_p <= ap_x * $signed({1'b0, r_wet_gain});
        end
        if (r_state == S_MIX) begin
            // wet and dry each rounded from Q2.14 gain before the sum
            r_mix <= MXW'(rnd_shift(64'(r_wet_p), 14) + rnd_shift(64'(r_dry_p), 14));
        end
        if (load_out) begin
            r_audio_out <= 16'(sat_to(rnd_shift(64'(r_mix), SH), 16));
        end
    end

`ifndef SYNTH
    // comb pipeline finishes only while the sequencer waits for it
    a_comb_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        comb_done |-> (r_state == S_COMB))
        else $error("comb bank finished outside the comb phase");

    // allpass chain finishes only while the sequencer waits for it
    a_ap_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ap_done |-> (r_state == S_AP))
        else $error("allpass chain finished outside the allpass phase");

    // a new result appears only from the final stage
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_OUT))
        else $error("output valid rose without a finished sample");

    // an accepted transaction starts the gain stage
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_GAIN))
        else $error("accepted sample did not start processing");
`endif

endmodule

// ----- rtl/carm_comb_bank.sv -----
`timescale 1ns / 1ps

module carm_comb_bank #(
    parameter int COMB_COUNT     = carm_pkg::CARM_COMB_COUNT,
    parameter int LONGEST_COMB   = carm_pkg::CARM_LONGEST_COMB,
    parameter int INTERNAL_WIDTH = carm_pkg::CARM_INTERNAL_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  carm_pkg::t_comb_cfg               i_cfg,
    input  logic                              i_start,
    input  logic signed [INTERNAL_WIDTH-1:0]  i_xin,
    output logic                              o_done,
    output logic signed [INTERNAL_WIDTH-1:0]  o_sum
);
    import carm_pkg::*;

    localparam int W     = INTERNAL_WIDTH;
    localparam int CW    = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
    localparam int PW    = $clog2(LONGEST_COMB);
    localparam int DEPTH = COMB_COUNT * LONGEST_COMB;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = W + 5;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LONGEST_COMB);
    localparam logic [CW-1:0]    LAST_C    = CW'(COMB_COUNT - 1);

    function automatic logic [LEN_W-1:0] line_len(input logic [CW-1:0] c);
        logic [LEN_W-1:0] tab;
        tab = COMB_LEN_TAB[4'(c)];
        return (tab > LEN_LIMIT) ? LEN_LIMIT : tab;
    endfunction

    // delay lines, one after another
    logic signed [W-1:0] r_line_mem [DEPTH];
    logic signed [W-1:0] r_rdata;

    logic [PW-1:0]       r_pos  [COMB_COUNT];
    logic                r_full [COMB_COUNT];
    logic signed [W-1:0] r_lp   [COMB_COUNT];

    logic signed [W-1:0]  r_xin;
    logic signed [SW-1:0] r_acc;

    logic          r_iss;
    logic [CW-1:0] r_ci;

    logic          r_s1_act, r_s1_live, r_s1_last, r_s1_full;
    logic [CW-1:0] r_s1_c;
    logic [PW-1:0] r_s1_pos;

    logic                 r_s2_act, r_s2_live, r_s2_last;
    logic [CW-1:0]        r_s2_c;
    logic [PW-1:0]        r_s2_pos;
    logic signed [W+17:0] r_s2_p1;
    logic signed [W+16:0] r_s2_p2;
    logic signed [W-1:0]  r_s2_o;

    logic                r_s3_act, r_s3_live, r_s3_last;
    logic [CW-1:0]       r_s3_c;
    logic [PW-1:0]       r_s3_pos;
    logic signed [W-1:0] r_s3_lp;

    logic                 r_s4_act, r_s4_live, r_s4_last;
    logic [CW-1:0]        r_s4_c;
    logic [PW-1:0]        r_s4_pos;
    logic signed [W+16:0] r_s4_fb;

    logic [AW-1:0]        rd_addr, wr_addr;
    logic                 iss_live;
    logic [16:0]          one_minus_d;
    logic signed [W-1:0]  s1_o;
    logic signed [W+17:0] s1_p1;
    logic signed [W+16:0] s1_p2;
    logic signed [W-1:0]  s2_lp;
    logic signed [W+16:0] s3_fb;
    logic signed [W-1:0]  s4_w;
    logic                 s4_we;
    logic [LEN_W-1:0]     s4_next;
    logic                 s4_wrap;

    assign iss_live = (line_len(r_ci) != '0);
    assign rd_addr  = AW'(r_ci) * AW'(LONGEST_COMB) + AW'(r_pos[r_ci]);

    // a line reads as zero until its first lap is written
    assign s1_o        = r_s1_full ? r_rdata : '0;
    assign one_minus_d = 17'h10000 - {1'b0, i_cfg.damp_coeff};
    assign s1_p1       = s1_o * $signed({1'b0, one_minus_d});
    assign s1_p2       = r_lp[r_s1_c] * $signed({1'b0, i_cfg.damp_coeff});

    assign s2_lp = W'(sat_to(rnd_shift(64'(r_s2_p1) + 64'(r_s2_p2), 16), W));
    assign s3_fb = r_s3_lp * $signed({1'b0, i_cfg.room_feedback});

    assign s4_w    = W'(sat_to(64'(r_xin) + rnd_shift(64'(r_s4_fb), 16), W));
    assign s4_we   = r_s4_act && r_s4_live;
    assign wr_addr = AW'(r_s4_c) * AW'(LONGEST_COMB) + AW'(r_s4_pos);
    assign s4_next = LEN_W'(r_s4_pos) + 1'b1;
    assign s4_wrap = (s4_next >= line_len(r_s4_c));

    always_ff @(posedge i_clk) begin
        if (s4_we) begin
            r_line_mem[wr_addr] <= s4_w;
        end
        r_rdata <= r_line_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss     <= 1'b0;
            r_ci      <= '0;
            r_s1_act  <= 1'b0;
            r_s1_live <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_act  <= 1'b0;
            r_s2_live <= 1'b0;
            r_s2_last <= 1'b0;
            r_s3_act  <= 1'b0;
            r_s3_live <= 1'b0;
            r_s3_last <= 1'b0;
            r_s4_act  <= 1'b0;
            r_s4_live <= 1'b0;
            r_s4_last <= 1'b0;
            for (int i = 0; i < COMB_COUNT; i++) begin
                r_pos[i]  <= '0;
                r_full[i] <= 1'b0;
                r_lp[i]   <= '0;
            end
        end else begin
            if (i_start) begin
                r_iss <= 1'b1;
                r_ci  <= '0;
            end else if (r_iss) begin
                if (r_ci == LAST_C) begin
                    r_iss <= 1'b0;
                end else begin
                    r_ci <= r_ci + 1'b1;
                end
            end

            r_s1_act  <= r_iss;
            r_s1_live <= r_iss && iss_live;
            r_s1_last <= (r_ci == LAST_C);
            r_s2_act  <= r_s1_act;
            r_s2_live <= r_s1_live;
            r_s2_last <= r_s1_last;
            r_s3_act  <= r_s2_act;
            r_s3_live <= r_s2_live;
            r_s3_last <= r_s2_last;
            r_s4_act  <= r_s3_act;
            r_s4_live <= r_s3_live;
            r_s4_last <= r_s3_last;

            if (r_s2_act && r_s2_live) begin
                r_lp[r_s2_c] <= s2_lp;
            end

            if (s4_we) begin
                r_pos[r_s4_c] <= s4_wrap ? '0 : PW'(s4_next);
                if (s4_wrap) begin
                    r_full[r_s4_c] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xin <= i_xin;
            r_acc <= '0;
        end else if (r_s2_act && r_s2_live) begin
            r_acc <= r_acc + SW'(r_s2_o);
        end

        r_s1_c    <= r_ci;
        r_s1_pos  <= r_pos[r_ci];
        r_s1_full <= r_full[r_ci];

        r_s2_c   <= r_s1_c;
        r_s2_pos <= r_s1_pos;
        r_s2_p1  <= s1_p1;
        r_s2_p2  <= s1_p2;
        r_s2_o   <= s1_o;

        r_s3_c   <= r_s2_c;
        r_s3_pos <= r_s2_pos;
        r_s3_lp  <= s2_lp;

        r_s4_c   <= r_s3_c;
        r_s4_pos <= r_s3_pos;
        r_s4_fb  <= s3_fb;
    end

    assign o_done = r_s4_act && r_s4_last;
    assign o_sum  = W'(sat_to(64'(r_acc), W));

endmodule

// ----- rtl/carm_allpass_chain.sv -----
`timescale 1ns / 1ps

module carm_allpass_chain #(
    parameter int ALLPASS_COUNT  = carm_pkg::CARM_ALLPASS_COUNT,
    parameter int INTERNAL_WIDTH = carm_pkg::CARM_INTERNAL_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [INTERNAL_WIDTH-1:0]  i_x,
    output logic                              o_done,
    output logic signed [INTERNAL_WIDTH-1:0]  o_x
);
    import carm_pkg::*;

    localparam int W     = INTERNAL_WIDTH;
    localparam int AIW   = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
    localparam int DEPTH = ALLPASS_COUNT * LONGEST_AP;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LONGEST_AP);
    localparam logic [AIW-1:0]   LAST_A    = AIW'(ALLPASS_COUNT - 1);

    function automatic logic [LEN_W-1:0] ap_len(input logic [AIW-1:0] a);
        logic [LEN_W-1:0] tab;
        tab = AP_LEN_TAB[3'(a)];
        return (tab > LEN_LIMIT) ? LEN_LIMIT : tab;
    endfunction

    logic signed [W-1:0] r_line_mem [DEPTH];
    logic signed [W-1:0] r_rdata;

    logic [AP_POS_W-1:0] r_pos  [ALLPASS_COUNT];
    logic                r_full [ALLPASS_COUNT];

    logic signed [W-1:0] r_x;
    logic                r_iss;
    logic [AIW-1:0]      r_ai;
    logic                r_s1_act, r_s1_live, r_s1_last, r_s1_full;
    logic [AIW-1:0]      r_s1_a;
    logic [AP_POS_W-1:0] r_s1_pos;
    logic                r_done;

    logic [AW-1:0]       rd_addr, wr_addr;
    logic signed [W-1:0] s1_b, s1_w, s1_xn;
    logic                s1_we;
    logic [LEN_W-1:0]    s1_next;
    logic                s1_wrap;

    assign rd_addr = AW'({r_ai, r_pos[r_ai]});
    assign wr_addr = AW'({r_s1_a, r_s1_pos});

    // stage math: line gets x + b/2, x becomes b - x
    assign s1_b    = r_s1_full ? r_rdata : '0;
    assign s1_w    = W'(sat_to(64'(r_x) + rnd_shift(64'(s1_b), 1), W));
    assign s1_xn   = W'(sat_to(64'(s1_b) - 64'(r_x), W));
    assign s1_we   = r_s1_act && r_s1_live;
    assign s1_next = LEN_W'(r_s1_pos) + 1'b1;
    assign s1_wrap = (s1_next >= ap_len(r_s1_a));

    always_ff @(posedge i_clk) begin
        if (s1_we) begin
            r_line_mem[wr_addr] <= s1_w;
        end
        r_rdata <= r_line_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss     <= 1'b0;
            r_ai      <= '0;
            r_s1_act  <= 1'b0;
            r_s1_live <= 1'b0;
            r_s1_last <= 1'b0;
            r_done    <= 1'b0;
            for (int i = 0; i < ALLPASS_COUNT; i++) begin
                r_pos[i]  <= '0;
                r_full[i] <= 1'b0;
            end
        end else begin
            if (i_start) begin
                r_iss <= 1'b1;
                r_ai  <= '0;
            end else if (r_iss) begin
                if (r_ai == LAST_A) begin
                    r_iss <= 1'b0;
                end else begin
                    r_ai <= r_ai + 1'b1;
                end
            end

            r_s1_act  <= r_iss;
            r_s1_live <= r_iss && (ap_len(r_ai) != '0);
            r_s1_last <= (r_ai == LAST_A);
            r_done    <= r_s1_act && r_s1_last;

            if (s1_we) begin
                r_pos[r_s1_a] <= s1_wrap ? '0 : AP_POS_W'(s1_next);
                if (s1_wrap) begin
                    r_full[r_s1_a] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
        end else if (s1_we) begin
            r_x <= s1_xn;
        end
        r_s1_a    <= r_ai;
        r_s1_pos  <= r_pos[r_ai];
        r_s1_full <= r_full[r_ai];
    end

    assign o_done = r_done;
    assign o_x    = r_x;

endmodule
